// File: hdl/mlr_pkg.sv
// Shared constants and types for the midpoint line rasterizer.
package mlr_pkg;

   // Coordinate width and the width of the signed decision arithmetic.
   localparam int COORD_BITS = 12;
   localparam int DEC_BITS   = COORD_BITS + 4;

   // Request modes.
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   // Kind of the line being drawn.
   typedef enum logic [1:0] {
      KIND_SHALLOW    = 2'd0,
      KIND_STEEP      = 2'd1,
      KIND_VERTICAL   = 2'd2,
      KIND_HORIZONTAL = 2'd3
   } kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NEG_SLOPE = 2'd1,
      ST_NO_LINE   = 2'd2
   } status_type;

endpackage

// File: hdl/midpoint_line_rasterizer_core.sv
// Midpoint line rasterizer core: one pixel response for every request.
// Throughput: one request per cycle while the response is not stalled; the setup or
// the step of one request is a single registered pass, and the decision variable feeds
// back through one add per cycle. Each result is held in the response register.
// Reset (synchronous, active high) clears the line state to an idle shallow line at the origin
// and empties the request and response registers.
module midpoint_line_rasterizer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [mlr_pkg::COORD_BITS-1:0]  req_start_x,
   input  logic [mlr_pkg::COORD_BITS-1:0]  req_start_y,
   input  logic [mlr_pkg::COORD_BITS-1:0]  req_end_x,
   input  logic [mlr_pkg::COORD_BITS-1:0]  req_end_y,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mlr_pkg::COORD_BITS-1:0]  rsp_pixel_x,
   output logic [mlr_pkg::COORD_BITS-1:0]  rsp_pixel_y,
   output logic                            rsp_last_pixel,
   output mlr_pkg::status_type             rsp_status
);
   import mlr_pkg::*;

   localparam int EXT_BITS = DEC_BITS - COORD_BITS;

   // Request register.
   logic                  req_valid_ff, req_valid_in;
   logic                  mode_ff;
   logic [COORD_BITS-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   // Line state.
   logic [COORD_BITS-1:0]      cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]      stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   logic signed [DEC_BITS-1:0] decision_ff, decision_in;
   logic signed [DEC_BITS-1:0] inc_straight_ff, inc_straight_in;
   logic signed [DEC_BITS-1:0] inc_diagonal_ff, inc_diagonal_in;
   kind_type                   line_kind_ff, line_kind_in;
   logic                       line_active_ff, line_active_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] pixel_x_ff, pixel_x_in, pixel_y_ff, pixel_y_in;
   logic                  last_ff, last_in;
   status_type            status_ff, status_in;

   // Handshake control.
   logic out_ready;
   logic process;
   logic accept;

   // Start setup signals.
   logic [COORD_BITS-1:0]      x0, y0, x1, y1;
   logic [COORD_BITS-1:0]      dx, dy;
   logic signed [DEC_BITS-1:0] dx_ext, dy_ext;
   logic                       swap_both;

   // Step signals.
   logic [COORD_BITS-1:0] cur_x_inc, cur_y_inc;
   logic                  step_last;

   // The request register advances whenever the response register can take a result.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign process   = req_valid_ff && out_ready;
   assign req_stall = req_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = pixel_x_ff;
   assign rsp_pixel_y    = pixel_y_ff;
   assign rsp_last_pixel = last_ff;
   assign rsp_status     = status_ff;

   // Endpoint ordering: swap when both coordinates decrease, then order axis-aligned lines.
   always_comb begin
      swap_both = (sx_ff > ex_ff) && (sy_ff > ey_ff);
      x0 = swap_both ? ex_ff : sx_ff;
      y0 = swap_both ? ey_ff : sy_ff;
      x1 = swap_both ? sx_ff : ex_ff;
      y1 = swap_both ? sy_ff : ey_ff;
      if (x0 == x1) begin
         if (y0 > y1) begin
            y0 = swap_both ? sy_ff : ey_ff;
            y1 = swap_both ? ey_ff : sy_ff;
         end
      end else if (y0 == y1) begin
         if (x0 > x1) begin
            x0 = swap_both ? sx_ff : ex_ff;
            x1 = swap_both ? ex_ff : sx_ff;
         end
      end
      dx     = x1 - x0;
      dy     = y1 - y0;
      dx_ext = {{EXT_BITS{1'b0}}, dx};
      dy_ext = {{EXT_BITS{1'b0}}, dy};
   end

   // Increments along each axis and the end test of a step.
   always_comb begin
      cur_x_inc = cur_x_ff + 1'b1;
      cur_y_inc = cur_y_ff + 1'b1;
      step_last = 1'b0;
   end

   // Next state of the line and of the response register.
   always_comb begin
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      stop_x_in       = stop_x_ff;
      stop_y_in       = stop_y_ff;
      decision_in     = decision_ff;
      inc_straight_in = inc_straight_ff;
      inc_diagonal_in = inc_diagonal_ff;
      line_kind_in    = line_kind_ff;
      line_active_in  = line_active_ff;
      pixel_x_in      = pixel_x_ff;
      pixel_y_in      = pixel_y_ff;
      last_in         = last_ff;
      status_in       = status_ff;

      if (process) begin
         if (mode_ff == MODE_START) begin
            if ((x0 != x1) && (y0 != y1) && ((x0 > x1) || (y0 > y1))) begin
               // Negative slope: reject and drop any active line.
               line_active_in = 1'b0;
               pixel_x_in     = '0;
               pixel_y_in     = '0;
               last_in        = 1'b0;
               status_in      = ST_NEG_SLOPE;
            end else begin
               decision_in     = '0;
               inc_straight_in = '0;
               inc_diagonal_in = '0;
               if (x0 == x1) begin
                  line_kind_in = KIND_VERTICAL;
               end else if (y0 == y1) begin
                  line_kind_in = KIND_HORIZONTAL;
               end else if (dy <= dx) begin
                  line_kind_in    = KIND_SHALLOW;
                  decision_in     = dx_ext - (dy_ext <<< 1);
                  inc_straight_in = -(dy_ext <<< 1);
                  inc_diagonal_in = (dx_ext - dy_ext) <<< 1;
               end else begin
                  line_kind_in    = KIND_STEEP;
                  decision_in     = (dx_ext <<< 1) - dy_ext;
                  inc_straight_in = dx_ext <<< 1;
                  inc_diagonal_in = (dx_ext - dy_ext) <<< 1;
               end
               cur_x_in   = x0;
               cur_y_in   = y0;
               stop_x_in  = x1;
               stop_y_in  = y1;
               // Only a vertical line can start on its end point (a single point).
               last_in    = (x0 == x1) && (y0 == y1);
               line_active_in = !((x0 == x1) && (y0 == y1));
               pixel_x_in = x0;
               pixel_y_in = y0;
               status_in  = ST_OK;
            end
         end else if (!line_active_ff) begin
            pixel_x_in = '0;
            pixel_y_in = '0;
            last_in    = 1'b0;
            status_in  = ST_NO_LINE;
         end else begin
            // Advance one pixel along the driving axis.
            unique case (line_kind_ff)
               KIND_SHALLOW: begin
                  cur_x_in = cur_x_inc;
                  if (decision_ff[DEC_BITS-1]) begin
                     cur_y_in    = cur_y_inc;
                     decision_in = decision_ff + inc_diagonal_ff;
                  end else begin
                     decision_in = decision_ff + inc_straight_ff;
                  end
               end
               KIND_STEEP: begin
                  cur_y_in = cur_y_inc;
                  if (decision_ff[DEC_BITS-1]) begin
                     decision_in = decision_ff + inc_straight_ff;
                  end else begin
                     cur_x_in    = cur_x_inc;
                     decision_in = decision_ff + inc_diagonal_ff;
                  end
               end
               KIND_VERTICAL: begin
                  cur_y_in = cur_y_inc;
               end
               default: begin
                  cur_x_in = cur_x_inc;
               end
            endcase
            if ((line_kind_ff == KIND_SHALLOW) || (line_kind_ff == KIND_HORIZONTAL)) begin
               last_in = step_last || (cur_x_in == stop_x_ff);
            end else begin
               last_in = step_last || (cur_y_in == stop_y_ff);
            end
            line_active_in = !last_in;
            pixel_x_in     = cur_x_in;
            pixel_y_in     = cur_y_in;
            status_in      = ST_OK;
         end
      end

      req_valid_in = accept ? 1'b1 : (process ? 1'b0 : req_valid_ff);
      rsp_valid_in = process ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cur_x_ff        <= '0;
         cur_y_ff        <= '0;
         stop_x_ff       <= '0;
         stop_y_ff       <= '0;
         decision_ff     <= '0;
         inc_straight_ff <= '0;
         inc_diagonal_ff <= '0;
         line_kind_ff    <= KIND_SHALLOW;
         line_active_ff  <= 1'b0;
      end else begin
         req_valid_ff    <= req_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         cur_x_ff        <= cur_x_in;
         cur_y_ff        <= cur_y_in;
         stop_x_ff       <= stop_x_in;
         stop_y_ff       <= stop_y_in;
         decision_ff     <= decision_in;
         inc_straight_ff <= inc_straight_in;
         inc_diagonal_ff <= inc_diagonal_in;
         line_kind_ff    <= line_kind_in;
         line_active_ff  <= line_active_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         sx_ff   <= req_start_x;
         sy_ff   <= req_start_y;
         ex_ff   <= req_end_x;
         ey_ff   <= req_end_y;
      end
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      last_ff    <= last_in;
      status_ff  <= status_in;
   end

   // A rejected or empty response carries no pixel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != ST_OK)) |->
         ((pixel_x_ff == '0) && (pixel_y_ff == '0) && !last_ff))
   else $error("non-pixel response carries pixel data");

   // A request held back by a stalled response stays in the request register.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !out_ready) |=> req_valid_ff)
   else $error("request lost while response stalled");

   // An active vertical line never leaves its column.
   assert property (@(posedge clock) disable iff (reset)
      (line_active_ff && (line_kind_ff == KIND_VERTICAL)) |-> (cur_x_ff == stop_x_ff))
   else $error("vertical line left its column");

   // An active horizontal line never leaves its row.
   assert property (@(posedge clock) disable iff (reset)
      (line_active_ff && (line_kind_ff == KIND_HORIZONTAL)) |-> (cur_y_ff == stop_y_ff))
   else $error("horizontal line left its row");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the midpoint line rasterizer core.
module testbench;
   import mlr_pkg::*;

   // Watchdog limit on cycles in a row with no handshake; reaching it ends the run.
   localparam int IDLE_LIMIT = 4000;

   // One pixel response, as the rasterizer should produce it.
   typedef struct {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last_pixel;
      status_type            status;
   } pixel_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = MODE_START;
   logic [COORD_BITS-1:0] req_start_x = '0;
   logic [COORD_BITS-1:0] req_start_y = '0;
   logic [COORD_BITS-1:0] req_end_x = '0;
   logic [COORD_BITS-1:0] req_end_y = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COORD_BITS-1:0] rsp_pixel_x;
   logic [COORD_BITS-1:0] rsp_pixel_y;
   logic                  rsp_last_pixel;
   status_type            rsp_status;

   // Line state mirrored by the pixel predictor.
   logic [COORD_BITS-1:0]      line_x = '0;
   logic [COORD_BITS-1:0]      line_y = '0;
   logic [COORD_BITS-1:0]      goal_x = '0;
   logic [COORD_BITS-1:0]      goal_y = '0;
   logic signed [DEC_BITS-1:0] err_acc = '0;
   logic signed [DEC_BITS-1:0] err_step_axis = '0;
   logic signed [DEC_BITS-1:0] err_step_diag = '0;
   kind_type                   line_shape = KIND_SHALLOW;
   logic                       line_live = 1'b0;

   pixel_rsp_type pending_pixels[$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int requests_sent = 0;
   int lines_started = 0;
   int pixel_steps = 0;
   int responses_checked = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   midpoint_line_rasterizer_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel),
      .rsp_status     (rsp_status)
   );

   // Clock generation.
   always #6 clock = ~clock;

   // The end point is reached along the driving axis of the line.
   function automatic logic at_goal();
      if (line_shape == KIND_SHALLOW || line_shape == KIND_HORIZONTAL)
         return line_x == goal_x;
      return line_y == goal_y;
   endfunction

   // Advances the predicted line state by one request and returns the expected pixel.
   function automatic pixel_rsp_type predict_pixel(input logic mode,
                                                   input logic [COORD_BITS-1:0] sx, sy, ex, ey);
      pixel_rsp_type r;
      logic [COORD_BITS-1:0] x0, y0, x1, y1, t;
      int a, b;
      r.pixel_x = '0;
      r.pixel_y = '0;
      r.last_pixel = 1'b0;
      r.status = ST_OK;
      if (mode == MODE_START) begin
         x0 = sx; y0 = sy; x1 = ex; y1 = ey;
         // Both coordinates decreasing: draw from the other end.
         if (x0 > x1 && y0 > y1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
         end
         err_acc = '0;
         err_step_axis = '0;
         err_step_diag = '0;
         if (x0 == x1) begin
            if (y0 > y1) begin
               t = y0; y0 = y1; y1 = t;
            end
            line_shape = KIND_VERTICAL;
         end else if (y0 == y1) begin
            if (x0 > x1) begin
               t = x0; x0 = x1; x1 = t;
            end
            line_shape = KIND_HORIZONTAL;
         end else if (x0 > x1 || y0 > y1) begin
            line_live = 1'b0;
            r.status = ST_NEG_SLOPE;
            return r;
         end else begin
            a = int'(y0) - int'(y1);
            b = int'(x1) - int'(x0);
            if (-a <= b) begin
               line_shape = KIND_SHALLOW;
               err_acc = DEC_BITS'(2 * a + b);
               err_step_axis = DEC_BITS'(2 * a);
            end else begin
               line_shape = KIND_STEEP;
               err_acc = DEC_BITS'(a + 2 * b);
               err_step_axis = DEC_BITS'(2 * b);
            end
            err_step_diag = DEC_BITS'(2 * (a + b));
         end
         line_x = x0; line_y = y0; goal_x = x1; goal_y = y1;
         r.last_pixel = at_goal();
         line_live = !r.last_pixel;
      end else if (!line_live) begin
         r.status = ST_NO_LINE;
         return r;
      end else begin
         // One midpoint step along the driving axis.
         case (line_shape)
            KIND_SHALLOW: begin
               line_x = line_x + 1'b1;
               if (err_acc < 0) begin
                  line_y = line_y + 1'b1;
                  err_acc = err_acc + err_step_diag;
               end else begin
                  err_acc = err_acc + err_step_axis;
               end
            end
            KIND_STEEP: begin
               line_y = line_y + 1'b1;
               if (err_acc < 0) begin
                  err_acc = err_acc + err_step_axis;
               end else begin
                  line_x = line_x + 1'b1;
                  err_acc = err_acc + err_step_diag;
               end
            end
            KIND_VERTICAL: line_y = line_y + 1'b1;
            default: line_x = line_x + 1'b1;
         endcase
         r.last_pixel = at_goal();
         if (r.last_pixel)
            line_live = 1'b0;
      end
      r.pixel_x = line_x;
      r.pixel_y = line_y;
      return r;
   endfunction

   // Sends one request after a random idle gap; called and returns at a falling edge.
   task automatic send_request(input logic mode, input logic [COORD_BITS-1:0] sx, sy, ex, ey);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      pending_pixels.push_back(predict_pixel(mode, sx, sy, ex, ey));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_start(input int x0, y0, x1, y1);
      lines_started++;
      send_request(MODE_START, COORD_BITS'(x0), COORD_BITS'(y0),
                   COORD_BITS'(x1), COORD_BITS'(y1));
   endtask

   // Step requests carry random coordinates, which the block ignores.
   task automatic send_step();
      pixel_steps++;
      send_request(MODE_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom), COORD_BITS'($urandom));
   endtask

   // Holds the sender off until every expected pixel has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_pixels.size() != 0)
         @(negedge clock);
   endtask

   // Field extremes, every line kind and every special case.
   task automatic test_directed();
      send_step();
      send_start(0, 0, 0, 0);
      send_start(4095, 4095, 4095, 4095);
      send_start(0, 4095, 4095, 0);
      send_start(4095, 0, 0, 4095);
      send_step();
      send_start(5, 7, 2, 7);
      repeat (3) send_step();
      send_start(4095, 4095, 4095, 4093);
      repeat (2) send_step();
      send_start(3, 3, 0, 1);
      repeat (3) send_step();
      // A steep line abandoned midway by the next start.
      send_start(100, 200, 101, 204);
      repeat (2) send_step();
      send_start(10, 10, 13, 13);
      repeat (3) send_step();
      send_step();
   endtask

   // One random line, mostly well formed and drawn to its end.
   task automatic draw_random_line();
      int span, lean, x0, y0, x1, y1, steps_left;
      span = ($urandom_range(19) == 0) ? $urandom_range(300, 17) : $urandom_range(16, 1);
      lean = $urandom_range(span, 1);
      x0 = $urandom_range(4095 - span);
      y0 = $urandom_range(4095 - span);
      x1 = x0;
      y1 = y0;
      steps_left = -1;
      case ($urandom_range(6))
         0: begin
            x1 = x0 + span;
            y1 = y0 + lean;
         end
         1: begin
            y1 = y0 + span;
            x1 = x0 + ((lean < span) ? lean : span - 1);
         end
         2: x1 = x0 + span;
         3: y1 = y0 + span;
         4: ;
         5: begin
            // Negative slope: rising x with falling y.
            x1 = x0 + span;
            y1 = y0;
            y0 = y0 + lean;
         end
         default: begin
            x0 = $urandom_range(4095);
            y0 = $urandom_range(4095);
            x1 = $urandom_range(4095);
            y1 = $urandom_range(4095);
            steps_left = $urandom_range(4);
         end
      endcase
      if ($urandom_range(15) == 0)
         steps_left = $urandom_range(3);
      if ($urandom_range(1))
         send_start(x1, y1, x0, y0);
      else
         send_start(x0, y0, x1, y1);
      while (line_live && steps_left != 0) begin
         send_step();
         steps_left--;
      end
      if ($urandom_range(7) == 0)
         send_step();
      if ($urandom_range(11) == 0)
         wait_for_drain();
   endtask

   // Random lines under one mix of sender gaps and receiver stalls.
   task automatic test_random_lines(input int send_pct, input int stall_in, input int count);
      int goal;
      goal = requests_sent + count;
      send_idle_pct = send_pct;
      stall_pct = stall_in;
      wait_for_drain();
      while (requests_sent < goal)
         draw_random_line();
   endtask

   // Receiver stalls, driven at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Compare each accepted response with the oldest expected pixel.
   always @(posedge clock) begin
      pixel_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         responses_checked++;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: x=%0d y=%0d last=%0b status=%0d",
                        rsp_pixel_x, rsp_pixel_y, rsp_last_pixel, rsp_status);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.pixel_x || rsp_pixel_y !== want.pixel_y ||
                rsp_last_pixel !== want.last_pixel || rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel mismatch: expected x=%0d y=%0d last=%0b status=%0d, %s",
                           want.pixel_x, want.pixel_y, want.last_pixel, want.status,
                           $sformatf("got x=%0d y=%0d last=%0b status=%0d", rsp_pixel_x,
                                     rsp_pixel_y, rsp_last_pixel, rsp_status));
            end
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d pixels outstanding", pending_pixels.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_lines(0, 0, 460);
      test_random_lines(86, 0, 460);
      test_random_lines(0, 86, 460);
      test_random_lines(24, 24, 460);
      req_valid <= 1'b0;
      stall_pct = 0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      $display("Ran %0d requests: %0d line starts and %0d pixel steps over four idle mixes.",
               requests_sent, lines_started, pixel_steps);
      $display("Compared %0d responses, %0d mismatched.", responses_checked, mismatches);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
